// File: src/htw_pkg.sv
// ----------------------------------------------------------------------------
// htw_pkg: shared types and constants for the hashed timer wheel
// Field widths, event and command codes, controller states and the
// command/status words between controller and datapath.
// ----------------------------------------------------------------------------
package htw_pkg;

	// pool and wheel geometry
	localparam int MAX_TIMERS = 16;
	localparam int ID_W       = $clog2(MAX_TIMERS);
	localparam int MAX_SLOTS  = 64;
	localparam int SLOT_W     = $clog2(MAX_SLOTS);
	localparam int CFG_W      = 7;
	localparam int EXP_W      = 20;
	localparam int TAG_W      = 16;
	localparam int KIND_W     = 3;
	localparam int CMD_W      = 2;

	// divider: dividend is current slot + expiry, one bit more than expiry
	localparam int DIV_W     = EXP_W + 1;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	// step counter covers both the divider and the entry walk
	localparam int CNT_W = (DIV_CNT_W > ID_W) ? DIV_CNT_W : ID_W;

	// command codes
	localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DEL  = 2'd2;

	// event kinds
	localparam logic [KIND_W-1:0] EV_ADDED    = 3'd0;
	localparam logic [KIND_W-1:0] EV_FULL     = 3'd1;
	localparam logic [KIND_W-1:0] EV_DELETED  = 3'd2;
	localparam logic [KIND_W-1:0] EV_NOTFOUND = 3'd3;
	localparam logic [KIND_W-1:0] EV_FIRED    = 3'd4;
	localparam logic [KIND_W-1:0] EV_IDLE     = 3'd5;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV_A,
		S_DIV_B_LD,
		S_DIV_B,
		S_ADD_WR,
		S_FULL,
		S_DEL,
		S_TICK
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic            accept;     // latch input word, load divider
		logic            div_step;   // one restoring division step
		logic            div_load_b; // keep slot, reload with expiry alone
		logic            add_write;  // write new entry, report added
		logic            add_full;   // report pool full
		logic            del_exec;   // delete entry, report result
		logic            tick_visit; // examine one entry of the walk
		logic            tick_end;   // flush last firing or idle, advance slot
		logic [ID_W-1:0] walk_idx;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
	} dp_stat_t;

endpackage

// File: src/htw_ctrl.sv
// ----------------------------------------------------------------------------
// htw_ctrl: command sequencer
// Steps the datapath through add (two divider passes), delete and the
// entry walk of a tick.
// ----------------------------------------------------------------------------
module htw_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [htw_pkg::CMD_W-1:0]  command,
	input  htw_pkg::dp_stat_t          stat,
	output logic                       busy,
	output htw_pkg::dp_cmd_t           cmd
);
	import htw_pkg::*;

	state_t           state_q, state_nxt;
	logic [CNT_W-1:0] cnt_q, cnt_nxt;
	logic             div_last, walk_last;

	assign div_last  = (cnt_q == CNT_W'(DIV_W - 1));
	assign walk_last = (cnt_q[ID_W-1:0] == ID_W'(MAX_TIMERS - 1));

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			cnt_q   <= cnt_nxt;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_nxt = state_q;
		cnt_nxt   = cnt_q;
		cmd       = '0;
		cmd.walk_idx = cnt_q[ID_W-1:0];
		busy      = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				cnt_nxt = '0;
				if (start) begin
					cmd.accept = 1'b1;
					case (command)
						CMD_TICK: state_nxt = S_TICK;
						CMD_ADD:  state_nxt = stat.full ? S_FULL : S_DIV_A;
						CMD_DEL:  state_nxt = S_DEL;
						default:  state_nxt = S_IDLE;
					endcase
				end
			end
			S_DIV_A: begin
				cmd.div_step = 1'b1;
				cnt_nxt = cnt_q + CNT_W'(1);
				if (div_last) begin
					cnt_nxt   = '0;
					state_nxt = S_DIV_B_LD;
				end
			end
			S_DIV_B_LD: begin
				cmd.div_load_b = 1'b1;
				state_nxt = S_DIV_B;
			end
			S_DIV_B: begin
				cmd.div_step = 1'b1;
				cnt_nxt = cnt_q + CNT_W'(1);
				if (div_last) begin
					cnt_nxt   = '0;
					state_nxt = S_ADD_WR;
				end
			end
			S_ADD_WR: begin
				cmd.add_write = 1'b1;
				state_nxt = S_IDLE;
			end
			S_FULL: begin
				cmd.add_full = 1'b1;
				state_nxt = S_IDLE;
			end
			S_DEL: begin
				cmd.del_exec = 1'b1;
				state_nxt = S_IDLE;
			end
			S_TICK: begin
				// walk all entries, then a closing step
				if (cnt_q[ID_W] == 1'b1) begin
					cmd.tick_end = 1'b1;
					cnt_nxt   = '0;
					state_nxt = S_IDLE;
				end else begin
					cmd.tick_visit = 1'b1;
					cnt_nxt = cnt_q + CNT_W'(1);
					if (walk_last)
						cnt_nxt = CNT_W'(1) << ID_W;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

endmodule

// File: src/htw_datapath.sv
// ----------------------------------------------------------------------------
// htw_datapath: timer pool, wheel position, divider and result register
// Holds the entries, the slot count register, a bit-serial restoring
// divider and the registered result word.
// ----------------------------------------------------------------------------
module htw_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  htw_pkg::dp_cmd_t            cmd,
	output htw_pkg::dp_stat_t           stat,
	input  logic [htw_pkg::ID_W-1:0]    timer_id,
	input  logic [htw_pkg::EXP_W-1:0]   expiry_ticks,
	input  logic [htw_pkg::TAG_W-1:0]   user_tag,
	input  logic                        cfg_we,
	input  logic [htw_pkg::CFG_W-1:0]   cfg_data,
	output logic                        result_strobe,
	output logic [htw_pkg::KIND_W-1:0]  event_kind,
	output logic [htw_pkg::ID_W-1:0]    timer_id_res,
	output logic [htw_pkg::TAG_W-1:0]   fired_tag,
	output logic                        last
);
	import htw_pkg::*;

	// entry pool
	logic [MAX_TIMERS-1:0] valid_q;
	logic [SLOT_W-1:0]     slot_q   [MAX_TIMERS];
	logic [EXP_W-1:0]      rounds_q [MAX_TIMERS];
	logic [TAG_W-1:0]      tag_q    [MAX_TIMERS];

	logic [CFG_W-1:0]  slots_cfg_q;
	logic [SLOT_W-1:0] cur_slot_q;
	logic [CFG_W-1:0]  n_eff;

	// latched input word
	logic [ID_W-1:0]  id_q;
	logic [EXP_W-1:0] exp_q;
	logic [TAG_W-1:0] utag_q;

	// divider
	logic [CFG_W-1:0]  rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [SLOT_W-1:0] new_slot_q;
	logic [CFG_W:0]    trial;
	logic              trial_ge;

	// pending firing of the running tick
	logic             pend_q;
	logic [ID_W-1:0]  pend_id_q;
	logic [TAG_W-1:0] pend_tag_q;

	logic [ID_W-1:0]  free_idx;
	logic             any_free;
	logic             hit;
	logic             fire;
	logic [CFG_W-1:0] slot_inc;

	// effective slot count, 1..MAX_SLOTS
	always_comb begin
		if (slots_cfg_q == '0)
			n_eff = CFG_W'(1);
		else if (slots_cfg_q > CFG_W'(MAX_SLOTS))
			n_eff = CFG_W'(MAX_SLOTS);
		else
			n_eff = slots_cfg_q;
	end

	// lowest free entry
	always_comb begin
		free_idx = '0;
		any_free = 1'b0;
		for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = ID_W'(i);
				any_free = 1'b1;
			end
		end
	end

	assign stat.full = !any_free;

	assign trial    = {rem_q, quo_q[DIV_W-1]};
	assign trial_ge = (trial >= {1'b0, n_eff});
	assign hit      = valid_q[cmd.walk_idx] && (slot_q[cmd.walk_idx] == cur_slot_q);
	assign fire     = cmd.tick_visit && hit && (rounds_q[cmd.walk_idx] == '0);
	assign slot_inc = {1'b0, cur_slot_q} + CFG_W'(1);

	// slot count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_cfg_q <= CFG_W'(MAX_SLOTS);
		end else if (cfg_we) begin
			slots_cfg_q <= cfg_data;
		end
	end

	// input latch and divider
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			id_q   <= timer_id;
			exp_q  <= expiry_ticks;
			utag_q <= user_tag;
			rem_q  <= '0;
			quo_q  <= {1'b0, expiry_ticks} + DIV_W'(cur_slot_q);
		end else if (cmd.div_load_b) begin
			new_slot_q <= rem_q[SLOT_W-1:0];
			rem_q      <= '0;
			quo_q      <= {1'b0, exp_q};
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? CFG_W'(trial - {1'b0, n_eff}) : trial[CFG_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], trial_ge};
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		if (cmd.add_write) begin
			slot_q[free_idx]   <= new_slot_q;
			rounds_q[free_idx] <= quo_q[EXP_W-1:0];
			tag_q[free_idx]    <= utag_q;
		end else if (cmd.tick_visit && hit && rounds_q[cmd.walk_idx] != '0) begin
			rounds_q[cmd.walk_idx] <= rounds_q[cmd.walk_idx] - EXP_W'(1);
		end
	end

	// pending firing payload
	always_ff @(posedge clk) begin
		if (fire) begin
			pend_id_q  <= cmd.walk_idx;
			pend_tag_q <= tag_q[cmd.walk_idx];
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (cmd.add_write) begin
			event_kind   <= EV_ADDED;
			timer_id_res <= free_idx;
			fired_tag    <= '0;
			last         <= 1'b1;
		end else if (cmd.add_full) begin
			event_kind   <= EV_FULL;
			timer_id_res <= '0;
			fired_tag    <= '0;
			last         <= 1'b1;
		end else if (cmd.del_exec) begin
			event_kind   <= valid_q[id_q] ? EV_DELETED : EV_NOTFOUND;
			timer_id_res <= id_q;
			fired_tag    <= '0;
			last         <= 1'b1;
		end else if (cmd.tick_visit) begin
			// an earlier firing goes out once a later one shows up
			event_kind   <= EV_FIRED;
			timer_id_res <= pend_id_q;
			fired_tag    <= pend_tag_q;
			last         <= 1'b0;
		end else if (cmd.tick_end && pend_q) begin
			event_kind   <= EV_FIRED;
			timer_id_res <= pend_id_q;
			fired_tag    <= pend_tag_q;
			last         <= 1'b1;
		end else begin
			event_kind   <= EV_IDLE;
			timer_id_res <= '0;
			fired_tag    <= '0;
			last         <= 1'b1;
		end
	end

	// control state: valid bits, wheel position, pending flag, strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			cur_slot_q    <= '0;
			pend_q        <= 1'b0;
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= cmd.add_write | cmd.add_full | cmd.del_exec | cmd.tick_end |
				(fire & pend_q);
			if (cmd.add_write)
				valid_q[free_idx] <= 1'b1;
			if (cmd.del_exec)
				valid_q[id_q] <= 1'b0;
			if (fire) begin
				valid_q[cmd.walk_idx] <= 1'b0;
				pend_q <= 1'b1;
			end
			if (cmd.tick_end) begin
				pend_q <= 1'b0;
				cur_slot_q <= (slot_inc >= n_eff) ? '0 : slot_inc[SLOT_W-1:0];
			end
		end
	end

endmodule

// File: src/hashed_timer_wheel.sv
// ----------------------------------------------------------------------------
// hashed_timer_wheel: hashed timing wheel with rotation counts
// Pool of 16 timers on a wheel of up to 64 slots; add, delete and tick
// commands, one result word per event.
// ----------------------------------------------------------------------------
// Usage: a command is taken when start is high and busy is low; busy falls in
// the cycle that puts the command's last result word on the ports, so the
// next command can be taken at the edge that takes that word. Results come on
// result_strobe for exactly one cycle each and cannot be held off; last
// marks the final word of a command. An add runs two 21-step passes of the
// bit-serial divider (slot and rotation count) with a load between them,
// then a write and the result word; a full pool and a delete each go
// straight to their result word. A tick walks the pool entries in turn,
// then a closing cycle and the result cycle; a firing goes out the cycle
// after the next firing is found, and the final one (or the idle word) the
// cycle after the closing cycle. Command 3 is taken and gives no result.
// cfg_data (slot count) is always ready and must be written only while the
// block is idle.
module hashed_timer_wheel (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [htw_pkg::CMD_W-1:0]   command,
	input  logic [htw_pkg::ID_W-1:0]    timer_id,
	input  logic [htw_pkg::EXP_W-1:0]   expiry_ticks,
	input  logic [htw_pkg::TAG_W-1:0]   user_tag,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [htw_pkg::CFG_W-1:0]   cfg_data,
	output logic                        result_strobe,
	output logic [htw_pkg::KIND_W-1:0]  event_kind,
	output logic [htw_pkg::ID_W-1:0]    timer_id_res,
	output logic [htw_pkg::TAG_W-1:0]   fired_tag,
	output logic                        last
);
	import htw_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	htw_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.stat    (stat),
		.busy    (busy),
		.cmd     (cmd)
	);

	htw_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.timer_id      (timer_id),
		.expiry_ticks  (expiry_ticks),
		.user_tag      (user_tag),
		.cfg_we        (cfg_valid & cfg_ready),
		.cfg_data      (cfg_data),
		.result_strobe (result_strobe),
		.event_kind    (event_kind),
		.timer_id_res  (timer_id_res),
		.fired_tag     (fired_tag),
		.last          (last)
	);

endmodule
